// ----- rtl/point_segment_distance_top_defines.svh -----
// Assertion macros used by the port-level point to segment distance checker.
`ifndef POINT_SEGMENT_DISTANCE_TOP_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_TOP_DEFINES_SVH
// Concurrent assertion on clock, masked while reset is high.
`define PSD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Concurrent assertion on clock that also holds during reset.
`define PSD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`endif

// ----- rtl/psd_pkg.sv -----
// Types and constants of the point to segment distance block.
`default_nettype none
package psd_pkg;
   localparam int COORD_BITS    = 16;
   localparam int FRACTION_BITS = 8;
   localparam int DIST_BITS     = 25;
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int LEN_W   = PROD_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int MAG_W   = SUM_W - 1;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int YW      = DIST_BITS + LEN_W;
   localparam int ACC_A   = SQ_W + 2 * FRACTION_BITS;
   localparam int ACC_B   = 2 * DIST_BITS + LEN_W + 1;
   localparam int ACC_W   = ((ACC_A > ACC_B) ? ACC_A : ACC_B) + 1;
   localparam int FRONT_STAGES = 5;
   localparam int LATENCY = FRONT_STAGES + DIST_BITS;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] distance_q8;
      logic                 outside;
   } rsp_type;

   // State of one item inside the digit recurrence.
   typedef struct packed {
      logic                 valid;
      logic                 outside;
      logic [LEN_W-1:0]     len;
      logic [ACC_W-1:0]     resid;
      logic [YW-1:0]        prod;
      logic [DIST_BITS-1:0] quot;
   } psd_iter_type;
endpackage
`default_nettype wire

// ----- rtl/psd_front.sv -----
// Front stages: differences, products, dot and cross sums, range test, squared cross.
`default_nettype none
module psd_front import psd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire req_type      req,
   output psd_iter_type      head
);
   logic                     v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, px_ff, py_ff;
   logic signed [PROD_W-1:0] dxx_ff, dyy_ff, pxdx_ff, pydy_ff, pxdy_ff, pydx_ff;
   logic [LEN_W-1:0]         len3_ff, len4_ff, len5_ff;
   logic signed [SUM_W-1:0]  dot_ff, crs_ff;
   logic                     out4_ff, out5_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic [ACC_W-1:0]         resid5_ff;
   logic [SQ_W-1:0]          sq_in;
   logic                     out_in;
   logic [SUM_W-1:0]         crs_abs;

   always_comb begin
      out_in = (len3_ff == '0) || dot_ff[SUM_W-1] ||
               (dot_ff > $signed({2'b00, len3_ff}));
      crs_abs = crs_ff[SUM_W-1] ? SUM_W'(-crs_ff) : SUM_W'(crs_ff);
      sq_in = mag_ff * mag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      dx_ff <= DIFF_W'(req.end_x) - DIFF_W'(req.start_x);
      dy_ff <= DIFF_W'(req.end_y) - DIFF_W'(req.start_y);
      px_ff <= DIFF_W'(req.point_x) - DIFF_W'(req.start_x);
      py_ff <= DIFF_W'(req.point_y) - DIFF_W'(req.start_y);
      dxx_ff  <= dx_ff * dx_ff;
      dyy_ff  <= dy_ff * dy_ff;
      pxdx_ff <= px_ff * dx_ff;
      pydy_ff <= py_ff * dy_ff;
      pxdy_ff <= px_ff * dy_ff;
      pydx_ff <= py_ff * dx_ff;
      len3_ff <= LEN_W'(unsigned'(dxx_ff)) + LEN_W'(unsigned'(dyy_ff));
      dot_ff  <= SUM_W'(pxdx_ff) + SUM_W'(pydy_ff);
      crs_ff  <= SUM_W'(pxdy_ff) - SUM_W'(pydx_ff);
      out4_ff <= out_in;
      len4_ff <= len3_ff;
      mag_ff  <= crs_abs[MAG_W-1:0];
      out5_ff <= out4_ff;
      len5_ff <= len4_ff;
      resid5_ff <= ACC_W'(sq_in) << (2 * FRACTION_BITS);
   end

   always_comb begin
      head.valid   = v5_ff;
      head.outside = out5_ff;
      head.len     = len5_ff;
      head.resid   = resid5_ff;
      head.prod    = '0;
      head.quot    = '0;
   end
endmodule
`default_nettype wire

// ----- rtl/psd_root.sv -----
// Digit recurrence: one quotient bit of cross * 2^F / |d| per pipeline stage.
`default_nettype none
module psd_root import psd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire psd_iter_type  head,
   output psd_iter_type       tail
);
   psd_iter_type stage_ff [DIST_BITS];
   psd_iter_type cur      [DIST_BITS+1];

   assign cur[0] = head;

   for (genvar i = 0; i < DIST_BITS; i++) begin : g_stage
      localparam int BIT = DIST_BITS - 1 - i;
      psd_iter_type stage_in;
      logic [ACC_W-1:0] step;

      // Trying bit BIT raises q^2*L by (q*L << BIT+1) + (L << 2*BIT).
      always_comb begin
         step = (ACC_W'(cur[i].prod) << (BIT + 1)) + (ACC_W'(cur[i].len) << (2 * BIT));
         stage_in = cur[i];
         if (step <= cur[i].resid) begin
            stage_in.resid     = cur[i].resid - step;
            stage_in.prod      = cur[i].prod + (YW'(cur[i].len) << BIT);
            stage_in.quot[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[i].valid <= 1'b0;
         end else begin
            stage_ff[i] <= stage_in;
         end
      end

      assign cur[i+1] = stage_ff[i];
   end

   assign tail = cur[DIST_BITS];
endmodule
`default_nettype wire

// ----- rtl/point_segment_distance_top.sv -----
// Top level of the point to segment distance pipeline.
// Pipeline: 5 front stages, then one stage per quotient bit of the 25-bit distance.
// Throughput: one item per cycle; busy is high only during reset and the cycle after it.
// Reset clears the valid bits and raises busy; results cannot be held off by the receiver.
`default_nettype none
module point_segment_distance_top import psd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);
   logic         busy_ff;
   psd_iter_type head;
   psd_iter_type tail;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end
   assign busy = busy_ff;

   psd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (start && !busy_ff),
      .req    (req_data),
      .head   (head)
   );

   psd_root u_root (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .tail  (tail)
   );

   always_comb begin
      rsp_valid            = tail.valid;
      rsp_data.outside     = tail.outside;
      rsp_data.distance_q8 = tail.outside ? '0 : tail.quot;
   end
endmodule
`default_nettype wire

// ----- rtl/psd_checker.sv -----
// Port-level checker for the point to segment distance block, bound to the top level.
`default_nettype none
`include "point_segment_distance_top_defines.svh"
module psd_assert_checker import psd_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);
   `PSD_ASSERT(a_latency, (start && !busy) |-> ##LATENCY rsp_valid, "item result missing")
   `PSD_ASSERT(a_no_spurious, rsp_valid |-> $past(start && !busy, LATENCY), "result without item")
   `PSD_ASSERT(a_outside_zero, (rsp_valid && rsp_data.outside) |-> (rsp_data.distance_q8 == '0), "outside distance")
   `PSD_ASSERT_ALWAYS(a_reset_busy, reset |=> busy, "busy low right after reset")
endmodule

bind point_segment_distance_top psd_assert_checker u_psd_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ----- tb/psd_checker.sv -----
// Checker that predicts and compares point to segment distance results.
`timescale 1ns / 1ps
module psd_checker import psd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count,
   output int           inside_count,
   output int           outside_count
);
   rsp_type expected_dist[$];

   // Exact distance: largest q with q^2 * |d|^2 <= cross^2 * 4^FRACTION_BITS.
   function automatic rsp_type predict_distance(req_type r);
      rsp_type res;
      logic signed [63:0] px, py, dx, dy, dot, len2, crs;
      logic [127:0] rhs, lhs;
      logic [63:0] q, t;
      px = 64'(r.point_x) - 64'(r.start_x);
      py = 64'(r.point_y) - 64'(r.start_y);
      dx = 64'(r.end_x) - 64'(r.start_x);
      dy = 64'(r.end_y) - 64'(r.start_y);
      len2 = dx * dx + dy * dy;
      dot = px * dx + py * dy;
      crs = px * dy - py * dx;
      res = '0;
      if (len2 == 0 || dot < 0 || dot > len2) begin
         res.outside = 1'b1;
         return res;
      end
      if (crs < 0) crs = -crs;
      rhs = (128'(crs) * 128'(crs)) << (2 * FRACTION_BITS);
      q = 0;
      for (int b = DIST_BITS - 1; b >= 0; b--) begin
         t = q | (64'd1 << b);
         lhs = 128'(t) * 128'(t) * 128'(len2);
         if (lhs <= rhs) q = t;
      end
      res.distance_q8 = q[DIST_BITS-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_res;
      if (reset) begin
         fail_count <= 0;
         inside_count <= 0;
         outside_count <= 0;
         pending_count <= 0;
      end else begin
         if (start && !busy) expected_dist.push_back(predict_distance(req_data));
         if (rsp_valid) begin
            if (expected_dist.size() == 0) begin
               $display("%0t: unexpected result, actual dist=%0d outside=%0b", $time,
                        rsp_data.distance_q8, rsp_data.outside);
               fail_count <= fail_count + 1;
            end else begin
               exp_res = expected_dist.pop_front();
               if (exp_res.outside) outside_count <= outside_count + 1;
               else inside_count <= inside_count + 1;
               if (rsp_data.distance_q8 !== exp_res.distance_q8 ||
                   rsp_data.outside !== exp_res.outside) begin
                  $display("%0t: mismatch, expected dist=%0d outside=%0b, actual dist=%0d outside=%0b",
                           $time, exp_res.distance_q8, exp_res.outside,
                           rsp_data.distance_q8, rsp_data.outside);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_dist.size();
      end
   end
endmodule

// ----- tb/tb_point_segment_distance_top.sv -----
// Testbench top: drives point and segment items and reports the verdict.
`timescale 1ns / 1ps
module tb_point_segment_distance_top;
   import psd_pkg::*;

   logic    clock, reset, start, busy, rsp_valid;
   req_type req_data;
   rsp_type rsp_data;
   int      fail_count, pending_count, inside_count, outside_count;
   int      sent_count;

   point_segment_distance_top u_dut (.*);
   psd_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("status: fail");
      $finish;
   end

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 40)) - 16'd20;
         default: return 16'($urandom);
      endcase
   endfunction

   // Random segment; most items project onto it so distances get exercised.
   function automatic req_type random_item();
      req_type r;
      int k;
      r.start_x = pick_coord();
      r.start_y = pick_coord();
      k = $urandom_range(0, 9);
      if (k == 0) begin
         r.end_x = r.start_x;
         r.end_y = r.start_y;
      end else begin
         r.end_x = pick_coord();
         r.end_y = pick_coord();
      end
      if (k < 7) begin
         // Point near the segment's midpoint, offset a little.
         r.point_x = 16'((32'(r.start_x) + 32'(r.end_x)) >>> 1) +
                     16'($urandom_range(0, 64)) - 16'd32;
         r.point_y = 16'((32'(r.start_y) + 32'(r.end_y)) >>> 1) +
                     16'($urandom_range(0, 64)) - 16'd32;
      end else begin
         r.point_x = pick_coord();
         r.point_y = pick_coord();
      end
      return r;
   endfunction

   // Holds the item until the block takes it; idles at random when allowed.
   task automatic send_item(req_type r, bit may_idle);
      while (may_idle && $urandom_range(0, 99) < 24) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_directed(int px, int py, int sx, int sy, int ex, int ey);
      req_type r;
      r.point_x = 16'(px); r.point_y = 16'(py);
      r.start_x = 16'(sx); r.start_y = 16'(sy);
      r.end_x = 16'(ex); r.end_y = 16'(ey);
      send_item(r, 1'b1);
   endtask

   initial begin
      int waited;
      start = 1'b0;
      req_data = '0;
      sent_count = 0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_directed(5, 3, 0, 0, 10, 0);
      send_directed(0, 7, 0, 0, 10, 0);               // projection on first end
      send_directed(10, -7, 0, 0, 10, 0);             // projection on second end
      send_directed(11, 1, 0, 0, 10, 0);              // past the far end
      send_directed(-1, 1, 0, 0, 10, 0);              // before the near end
      send_directed(4, 4, 4, 4, 4, 4);                // zero-length segment
      send_directed(9, 9, 3, 3, 3, 3);
      send_directed(1, 0, 0, 0, 3, 3);                // irrational distance
      send_directed(-32768, -32768, -32768, -32768, 32767, 32767);
      send_directed(32767, -32768, -32768, -32768, 32767, 32767);
      send_directed(-32768, 32767, -32768, -32768, 32767, 32767);
      send_directed(0, 32767, -32768, 0, 32767, 0);
      send_directed(32767, 32767, -32768, -32768, -32768, 32767);
      send_directed(-1, -1, 0, 0, -1, -1);
      send_directed(0, 0, 32767, 32767, -32768, -32768);
      send_directed(-32768, 32767, 32767, -32768, 32767, -32767);
      // Let the pipeline drain before the random part.
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      for (int i = 0; i < 600; i++) begin
         send_item(random_item(), !(i >= 200 && i < 320));
         if (i == 400) begin
            start <= 1'b0;
            while (pending_count != 0) @(posedge clock);
         end
      end
      start <= 1'b0;
      waited = 0;
      while (pending_count != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d items; %0d results inside the segment, %0d outside.",
               sent_count, inside_count, outside_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
